[design/lpff_pkg.sv]
// package for the length-prefixed frame fifo: payload structs, request and
// status codes, and the command/status structs between controller and datapath
`default_nettype none

package lpff_pkg;

  localparam int DATA_W = 8;
  localparam int CFG_W  = 9;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_BADLEN  = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DATA_W-1:0] data_in;
    logic [DATA_W-1:0] frame_len;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic [DATA_W-1:0] frame_len_out;
    logic              last;
    logic [2:0]        status;
  } out_item_t;

  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic finish_rd;  // memory data ready, retire the pending pop
    logic cfg_write;  // ring size register written
  } lpff_cmd_t;

  typedef struct packed {
    logic pop_needed; // accepted item would pop a byte from the ring
    logic out_free;   // output register can take a new result
  } lpff_stat_t;

endpackage

`default_nettype wire

[design/lpff_ctrl.sv]
// controller for the length-prefixed frame fifo: handshakes and the two-state
// sequencer around the registered ring read; uses lpff_pkg
`default_nettype none

module lpff_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire lpff_pkg::lpff_stat_t stat,
  output lpff_pkg::lpff_cmd_t     cmd
);
  import lpff_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RD   = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    in_stall      = !((state == S_IDLE) && stat.out_free);
    cfg_ready     = (state == S_IDLE);
    cmd.accept    = in_valid && !in_stall;
    cmd.finish_rd = (state == S_RD) && stat.out_free;
    cmd.cfg_write = cfg_valid && cfg_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept && stat.pop_needed) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (cmd.finish_rd) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/lpff_dp.sv]
// datapath for the length-prefixed frame fifo: ring memory, indices, frame
// counters, size register and output register; uses lpff_pkg
`default_nettype none

module lpff_dp #(
  parameter int DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lpff_pkg::in_item_t          in_item,
  input  wire logic [lpff_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        out_stall,
  output logic                             out_valid,
  output lpff_pkg::out_item_t              out_item,
  input  wire lpff_pkg::lpff_cmd_t         cmd,
  output lpff_pkg::lpff_stat_t             stat
);
  import lpff_pkg::*;

  localparam int RING_MAX = (DEPTH < 256) ? DEPTH : 256;
  localparam int IDX_W    = $clog2(RING_MAX);
  localparam int SZ_W     = $clog2(RING_MAX + 1);
  localparam logic [SZ_W-1:0] SZ_MAX = SZ_W'(RING_MAX);
  localparam logic [SZ_W-1:0] SZ_MIN = SZ_W'(2);

  logic [DATA_W-1:0] ring [RING_MAX];
  logic [DATA_W-1:0] mem_q;

  logic [SZ_W-1:0]   size;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic [IDX_W-1:0]  wr_idx, wr_idx_next;
  logic [DATA_W-1:0] wr_left, wr_left_next;
  logic [DATA_W-1:0] rd_left, rd_left_next;
  logic [DATA_W-1:0] cur_len, cur_len_next;

  logic [SZ_W-1:0]   used;
  logic [SZ_W-1:0]   free_cnt;
  logic [IDX_W-1:0]  wr_inc, rd_inc;
  logic [SZ_W-1:0]   wr_sum, rd_sum;
  logic              push;
  logic [DATA_W-1:0] push_data;
  logic              load;
  out_item_t         res;
  logic [SZ_W-1:0]   cfg_size;

  // used count and wrapped successors of both indices
  always_comb begin
    if (wr_idx >= rd_idx) begin
      used = SZ_W'(wr_idx) - SZ_W'(rd_idx);
    end else begin
      used = size - (SZ_W'(rd_idx) - SZ_W'(wr_idx));
    end
    free_cnt = size - used - SZ_W'(1);
    wr_sum   = SZ_W'(wr_idx) + SZ_W'(1);
    rd_sum   = SZ_W'(rd_idx) + SZ_W'(1);
    wr_inc   = (wr_sum >= size) ? '0 : wr_sum[IDX_W-1:0];
    rd_inc   = (rd_sum >= size) ? '0 : rd_sum[IDX_W-1:0];
  end

  always_comb begin
    stat.pop_needed = (in_item.req_type == REQ_READ) && (rd_idx != wr_idx);
    stat.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    cfg_size = (cfg_data < CFG_W'(SZ_MIN)) ? SZ_MIN :
               (cfg_data > CFG_W'(SZ_MAX)) ? SZ_MAX : cfg_data[SZ_W-1:0];
  end

  always_comb begin
    rd_idx_next  = rd_idx;
    wr_idx_next  = wr_idx;
    wr_left_next = wr_left;
    rd_left_next = rd_left;
    cur_len_next = cur_len;
    push         = 1'b0;
    push_data    = in_item.data_in;
    res.data_out      = '0;
    res.frame_len_out = cur_len;
    res.last          = 1'b0;
    res.status        = ST_IGNORED;

    if (cmd.finish_rd) begin
      if (rd_left == '0) begin
        // length byte at a frame boundary
        res.frame_len_out = mem_q;
        if (mem_q == '0 || {1'b0, mem_q} > 9'(used)) begin
          rd_idx_next  = wr_idx;
          wr_left_next = '0;
          rd_left_next = '0;
          cur_len_next = '0;
          res.status   = ST_BADLEN;
        end else begin
          rd_idx_next  = rd_inc;
          rd_left_next = mem_q;
          cur_len_next = mem_q;
          res.status   = ST_OK;
        end
      end else begin
        res.data_out = mem_q;
        rd_idx_next  = rd_inc;
        rd_left_next = rd_left - DATA_W'(1);
        res.last     = (rd_left == DATA_W'(1));
        res.status   = ST_OK;
      end
    end else if (cmd.accept) begin
      case (in_item.req_type)
        REQ_START: begin
          if (wr_left != '0) begin
            res.status = ST_IGNORED;
          end else if ({1'b0, free_cnt} >= 10'(in_item.frame_len) + 10'd1) begin
            push         = 1'b1;
            push_data    = in_item.frame_len;
            wr_idx_next  = wr_inc;
            wr_left_next = in_item.frame_len;
            res.status   = ST_OK;
          end else begin
            res.status = ST_NOSPACE;
          end
        end
        REQ_WRITE: begin
          if (wr_left == '0) begin
            res.status = ST_IGNORED;
          end else if (wr_inc == rd_idx) begin
            res.status = ST_NOSPACE;
          end else begin
            push         = 1'b1;
            wr_idx_next  = wr_inc;
            wr_left_next = wr_left - DATA_W'(1);
            res.status   = ST_OK;
          end
        end
        REQ_READ: begin
          if (rd_idx == wr_idx) begin
            res.status = ST_EMPTY;
          end
        end
        default: res.status = ST_IGNORED;
      endcase
    end
  end

  assign load = (cmd.accept && !stat.pop_needed) || cmd.finish_rd;

  always_ff @(posedge clk) begin
    if (push) begin
      ring[wr_idx] <= push_data;
    end
    if (cmd.accept && stat.pop_needed) begin
      mem_q <= ring[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= SZ_MAX;
      rd_idx  <= '0;
      wr_idx  <= '0;
      wr_left <= '0;
      rd_left <= '0;
      cur_len <= '0;
    end else if (cmd.cfg_write) begin
      size    <= cfg_size;
      rd_idx  <= '0;
      wr_idx  <= '0;
      wr_left <= '0;
      rd_left <= '0;
      cur_len <= '0;
    end else begin
      rd_idx  <= rd_idx_next;
      wr_idx  <= wr_idx_next;
      wr_left <= wr_left_next;
      rd_left <= rd_left_next;
      cur_len <= cur_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

[design/length_prefixed_frame_fifo_top.sv]
// Length-prefixed frame fifo: a byte ring holding frames, each stored as a
// length byte followed by that many data bytes, one slot always kept empty.
// Every request gives exactly one result item. Start and write requests, and
// reads of an empty ring, load their result into the output register
// directly; a read that pops a byte goes first through the registered read
// port of the ring memory. The result waits in an output register; while a
// result is held there by a stall the input is stalled too, and a new request
// is taken in the cycle the held result leaves. Writing the size register
// empties the ring. Depends on lpff_pkg, lpff_ctrl and lpff_dp.
`default_nettype none

module length_prefixed_frame_fifo_top #(
  parameter int DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire lpff_pkg::in_item_t          in_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output lpff_pkg::out_item_t              out_item,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lpff_pkg::CFG_W-1:0]  cfg_data
);
  import lpff_pkg::*;

  lpff_cmd_t  cmd;
  lpff_stat_t stat;

  lpff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpff_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire
